[src/icp_pkg.sv]
`default_nettype none
package icp_pkg;

  // Number format: two's complement, DW bits with FRAC fraction bits.
  localparam int DW    = 32;
  localparam int FRAC  = 16;
  // Quotient width of the fixed-point divide: (|a| << FRAC) / |b|.
  localparam int QW    = DW + FRAC;
  // Full product width and the widest magnitude that saturation must see.
  localparam int PW    = 2 * DW;
  localparam int MW    = ((PW - FRAC) > QW) ? (PW - FRAC) : QW;
  localparam int CNT_W = $clog2(QW);

  // Operator codes on the input channel.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_PLUS   = 3'd0;
  localparam logic [OP_W-1:0] OP_MINUS  = 3'd1;
  localparam logic [OP_W-1:0] OP_TIMES  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIVIDE = 3'd3;
  localparam logic [OP_W-1:0] OP_EQUALS = 3'd4;

  // Pending multiplicative operator.
  localparam int MP_W = 2;
  localparam logic [MP_W-1:0] MP_NONE   = 2'd0;
  localparam logic [MP_W-1:0] MP_TIMES  = 2'd1;
  localparam logic [MP_W-1:0] MP_DIVIDE = 2'd2;

  // Pending additive operator.
  localparam logic ADD_PLUS  = 1'b0;
  localparam logic ADD_MINUS = 1'b1;

  // Result status codes.
  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_DIV0 = 2'd1;
  localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

  // Bits of the sticky error flags.
  localparam int ERR_DIV0_BIT = 0;
  localparam int ERR_OVF_BIT  = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture an accepted item
    logic mul;       // register the magnitude product
    logic div_step;  // one restoring-divide step
    logic term;      // resolve the new term value
    logic combine;   // fold the term into the sum
    logic emit;      // load the output register and clear the state
  } icp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            op_ok;     // operator on the input channel is known
    logic [MP_W-1:0] mp;        // pending multiplicative operator
    logic            op_mul;    // captured operator is times or divide
    logic            op_eq;     // captured operator is equals
    logic            div_last;  // the divider is on its last step
    logic            out_free;  // the output register can take a result
  } icp_sts_t;

endpackage
`default_nettype wire

[src/icp_in_if.sv]
`default_nettype none
// Input channel: one operand and the operator written after it.
interface icp_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [icp_pkg::DW-1:0]   operand;
  logic        [icp_pkg::OP_W-1:0] next_op;

  modport source (output valid, output operand, output next_op, input ready);
  modport sink   (input valid, input operand, input next_op, output ready);
endinterface
`default_nettype wire

[src/icp_out_if.sv]
`default_nettype none
// Result channel: expression value and its status.
interface icp_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [icp_pkg::DW-1:0]   result;
  logic        [icp_pkg::ST_W-1:0] status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface
`default_nettype wire

[src/infix_calculator_two_precedence_unit.sv]
`default_nettype none
// Two-precedence infix calculator, signed Q16.16.
// in_ch carries one operand and the operator written after it (plus, minus,
// times, divide, equals); a transaction completes when valid and ready are
// both high. Times and divide bind tighter than plus and minus. Only an
// equals transaction produces a result on out_ch: the value of the whole
// expression and a status (ok, division by zero, overflow saturated).
// Unknown operator codes are accepted and have no effect.
// Timing: in_ready is high only while the unit is idle. An accepted item with
// a known operator then goes through the term step; if it closes a term with
// times pending it is multiplied first, and with divide pending the restoring
// divider runs first, producing one of the 48 quotient bits per cycle. Items
// with plus, minus or equals then take a combine step to fold the term into
// the sum. The result of equals is in the output register at the edge where
// the unit returns to idle. The output register decouples the two sides: new
// items are accepted while a result waits; an equals item holds in its final
// step only while the previous result is still untaken. Synchronous active-low
// reset clears the expression state and empties the output register.
module infix_calculator_two_precedence_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  icp_in_if.sink    in_ch,
  icp_out_if.source out_ch
);

  icp_pkg::icp_cmd_t cmd;
  icp_pkg::icp_sts_t sts;

  icp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  icp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_operand (in_ch.operand),
    .in_next_op (in_ch.next_op),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_ch.result),
    .out_status (out_ch.status)
  );

endmodule
`default_nettype wire

[src/icp_ctrl.sv]
`default_nettype none
// Sequencer for one item: capture, optional multiply or divide, term, and combine for plus, minus or equals.
module icp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire icp_pkg::icp_sts_t sts,
  output icp_pkg::icp_cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_TERM = 5'b01000,
    S_COMB = 5'b10000
  } icp_state_t;

  icp_state_t state_r;
  icp_state_t state_nxt;
  logic       take;

  assign in_ready = (state_r == S_IDLE);
  // Items with an unknown operator are accepted and dropped.
  assign take     = in_valid && in_ready && sts.op_ok;

  // Command decode.
  always_comb begin
    cmd          = '0;
    cmd.load     = take;
    cmd.mul      = (state_r == S_MUL);
    cmd.div_step = (state_r == S_DIV);
    cmd.term     = (state_r == S_TERM);
    cmd.combine  = (state_r == S_COMB) && (!sts.op_eq || sts.out_free);
    cmd.emit     = (state_r == S_COMB) && sts.op_eq && sts.out_free;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (sts.mp)
            icp_pkg::MP_TIMES:  state_nxt = S_MUL;
            icp_pkg::MP_DIVIDE: state_nxt = S_DIV;
            default:            state_nxt = S_TERM;
          endcase
        end
      end
      S_MUL:  state_nxt = S_TERM;
      S_DIV: begin
        if (sts.div_last) state_nxt = S_TERM;
      end
      S_TERM: state_nxt = sts.op_mul ? S_IDLE : S_COMB;
      S_COMB: begin
        if (cmd.combine) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[src/icp_dp.sv]
`default_nettype none
// Expression state, multiplier, restoring divider, saturation and output register.
module icp_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire icp_pkg::icp_cmd_t                  cmd,
  output icp_pkg::icp_sts_t                       sts,
  input  wire logic signed [icp_pkg::DW-1:0]      in_operand,
  input  wire logic        [icp_pkg::OP_W-1:0]    in_next_op,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [icp_pkg::DW-1:0]           out_result,
  output logic        [icp_pkg::ST_W-1:0]         out_status
);

  localparam int DW    = icp_pkg::DW;
  localparam int FRAC  = icp_pkg::FRAC;
  localparam int QW    = icp_pkg::QW;
  localparam int PW    = icp_pkg::PW;
  localparam int MW    = icp_pkg::MW;
  localparam int CNT_W = icp_pkg::CNT_W;
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
    mag_of = v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  // Architectural state.
  logic [DW-1:0]           sum_r, sum_nxt;
  logic                    add_r, add_nxt;
  logic [DW-1:0]           term_r, term_nxt;
  logic [icp_pkg::MP_W-1:0] mp_r, mp_nxt;
  logic [1:0]              err_r, err_nxt;

  // Captured item and arithmetic registers.
  logic [DW-1:0]           x_r;
  logic [icp_pkg::OP_W-1:0] op_r;
  logic                    neg_r;
  logic                    a_neg_r;
  logic [DW-1:0]           ma_r;
  logic [DW-1:0]           mb_r;
  logic [PW-1:0]           prod_r;
  logic [QW-1:0]           n_r;
  logic [QW-1:0]           q_r;
  logic [DW-1:0]           rem_r;
  logic [CNT_W-1:0]        cnt_r;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [DW-1:0]           out_result_r;
  logic [icp_pkg::ST_W-1:0] out_status_r;

  // Divider step.
  logic [DW:0]             rem2;
  logic [DW:0]             rem_diff;
  logic                    q_bit;

  // Term resolution.
  logic [MW-1:0]           m_sel;
  logic [MW-1:0]           limit;
  logic                    t_ovf;
  logic [DW-1:0]           t_mag;
  logic [DW-1:0]           t_built;
  logic [DW-1:0]           t_val;
  logic                    t_ovf_flag;
  logic                    t_div0;

  // Sum update.
  logic [DW:0]             s_wide;
  logic                    s_ovf;
  logic [DW-1:0]           s_val;
  logic [1:0]              err_fin;

  // Status to the controller.
  always_comb begin
    sts          = '0;
    sts.op_ok    = (in_next_op <= icp_pkg::OP_EQUALS);
    sts.mp       = mp_r;
    sts.op_mul   = (op_r == icp_pkg::OP_TIMES) || (op_r == icp_pkg::OP_DIVIDE);
    sts.op_eq    = (op_r == icp_pkg::OP_EQUALS);
    sts.div_last = (cnt_r == CNT_W'(QW - 1));
    sts.out_free = !out_valid_r || out_ready;
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem2     = {rem_r, n_r[QW-1]};
  assign rem_diff = rem2 - {1'b0, mb_r};
  assign q_bit    = (rem2 >= {1'b0, mb_r});

  // Saturate the product or quotient magnitude and apply the sign.
  assign m_sel   = (mp_r == icp_pkg::MP_TIMES) ? MW'(prod_r >> FRAC) : MW'(q_r);
  assign limit   = MW'(MAXV) + MW'(neg_r);
  assign t_ovf   = (m_sel > limit);
  assign t_mag   = m_sel[DW-1:0];
  assign t_built = neg_r ? (~t_mag + DW'(1)) : t_mag;

  always_comb begin
    t_val      = x_r;
    t_ovf_flag = 1'b0;
    t_div0     = 1'b0;
    unique case (mp_r)
      icp_pkg::MP_TIMES: begin
        t_val      = t_ovf ? (neg_r ? MINV : MAXV) : t_built;
        t_ovf_flag = t_ovf;
      end
      icp_pkg::MP_DIVIDE: begin
        if (mb_r == '0) begin
          t_val  = a_neg_r ? MINV : MAXV;
          t_div0 = 1'b1;
        end else begin
          t_val      = t_ovf ? (neg_r ? MINV : MAXV) : t_built;
          t_ovf_flag = t_ovf;
        end
      end
      default: t_val = x_r;
    endcase
  end

  // Saturating add or subtract of the term into the sum.
  assign s_wide  = (add_r == icp_pkg::ADD_MINUS)
                 ? ({sum_r[DW-1], sum_r} - {term_r[DW-1], term_r})
                 : ({sum_r[DW-1], sum_r} + {term_r[DW-1], term_r});
  assign s_ovf   = (s_wide[DW] != s_wide[DW-1]);
  assign s_val   = s_ovf ? (s_wide[DW] ? MINV : MAXV) : s_wide[DW-1:0];
  assign err_fin = err_r | {s_ovf, 1'b0};

  // Next architectural state.
  always_comb begin
    sum_nxt  = sum_r;
    add_nxt  = add_r;
    term_nxt = term_r;
    mp_nxt   = mp_r;
    err_nxt  = err_r;
    if (cmd.term) begin
      term_nxt = t_val;
      err_nxt  = err_r | {t_ovf_flag, t_div0};
      if (op_r == icp_pkg::OP_TIMES) begin
        mp_nxt = icp_pkg::MP_TIMES;
      end else if (op_r == icp_pkg::OP_DIVIDE) begin
        mp_nxt = icp_pkg::MP_DIVIDE;
      end
    end
    if (cmd.combine) begin
      if (cmd.emit) begin
        sum_nxt = '0;
        add_nxt = icp_pkg::ADD_PLUS;
        err_nxt = '0;
      end else begin
        sum_nxt = s_val;
        add_nxt = (op_r == icp_pkg::OP_MINUS) ? icp_pkg::ADD_MINUS : icp_pkg::ADD_PLUS;
        err_nxt = err_fin;
      end
      term_nxt = '0;
      mp_nxt   = icp_pkg::MP_NONE;
    end
  end

  // Output register: filled on emit, emptied when the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      add_r       <= icp_pkg::ADD_PLUS;
      term_r      <= '0;
      mp_r        <= icp_pkg::MP_NONE;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      add_r       <= add_nxt;
      term_r      <= term_nxt;
      mp_r        <= mp_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_operand;
      op_r    <= in_next_op;
      neg_r   <= term_r[DW-1] ^ in_operand[DW-1];
      a_neg_r <= term_r[DW-1];
      ma_r    <= mag_of(term_r);
      mb_r    <= mag_of(in_operand);
      n_r     <= QW'(mag_of(term_r)) << FRAC;
      q_r     <= '0;
      rem_r   <= '0;
      cnt_r   <= '0;
    end
    if (cmd.mul) begin
      prod_r <= PW'(ma_r) * PW'(mb_r);
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? rem_diff[DW-1:0] : rem2[DW-1:0];
      q_r   <= {q_r[QW-2:0], q_bit};
      n_r   <= {n_r[QW-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.emit) begin
      out_result_r <= s_val;
      if (err_fin[icp_pkg::ERR_DIV0_BIT]) begin
        out_status_r <= icp_pkg::ST_DIV0;
      end else if (err_fin[icp_pkg::ERR_OVF_BIT]) begin
        out_status_r <= icp_pkg::ST_OVF;
      end else begin
        out_status_r <= icp_pkg::ST_OK;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

[src/icp_checker.sv]
`default_nettype none
// Port-level checks for the calculator.
module icp_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [icp_pkg::OP_W-1:0]   in_next_op,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [icp_pkg::DW-1:0]     out_result,
  input wire logic [icp_pkg::ST_W-1:0]   out_status
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result) && $stable(out_status))
    else $error("result changed while stalled");

  // Status is one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == icp_pkg::ST_OK) || (out_status == icp_pkg::ST_DIV0)
                  || (out_status == icp_pkg::ST_OVF))
    else $error("undefined status code");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // An accepted item with a known operator leaves the unit busy in the cycle after.
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_next_op <= icp_pkg::OP_EQUALS) |=> !in_ready)
    else $error("item accepted while the previous one is in work");

endmodule

bind infix_calculator_two_precedence_unit icp_checker u_icp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_next_op (in_ch.next_op),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result),
  .out_status (out_ch.status)
);
`default_nettype wire
